>>> design/aph_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aph_pkg
// shared types and constants for the arc point hit test pipeline
// ----------------------------------------------------------------------------
package aph_pkg;

  // cordic datapath width and angle widths
  localparam int unsigned XW = 64;
  localparam int unsigned ZW = 32;
  localparam int unsigned AW = 16;

  // round(2^32 / cordic gain)
  localparam logic [31:0] INV_GAIN = 32'h9B74_EDA8;

  // half a turn and half an output angle lsb
  localparam logic [ZW-1:0] HALF_TURN = 32'h8000_0000;
  localparam logic [ZW-1:0] ANG_ROUND = 32'h0000_8000;

  // atan(2^-i) in 2^32 units per turn
  localparam logic [ZW-1:0] ATAN_TAB [0:31] = '{
    32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4, 32'h028B_0D43,
    32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55, 32'h0028_BE53, 32'h0014_5F2F,
    32'h000A_2F98, 32'h0005_17CC, 32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA,
    32'h0000_517D, 32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
    32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051, 32'h0000_0029,
    32'h0000_0014, 32'h0000_000A, 32'h0000_0005, 32'h0000_0003, 32'h0000_0001,
    32'h0000_0001, 32'h0000_0000
  };

  // configuration register map
  typedef enum logic [1:0] {
    REG_RADIUS = 2'd0,
    REG_START  = 2'd1,
    REG_END    = 2'd2,
    REG_TOL    = 2'd3
  } reg_idx_t;

endpackage

>>> design/arc_point_hit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arc_point_hit_test
// pipelined test of a probe point against a circular arc: cordic vectoring
// gives distance and angle of the offset from the hub, then radial and
// sweep checks against the configured arc
// ----------------------------------------------------------------------------
//
//  channel | handshake                    | payload
//  --------+------------------------------+----------------------------------
//  in      | in_valid / in_ready          | probe_x, probe_y, hub_x, hub_y
//  out     | out_valid / out_ready        | is_near, radial_ok, in_sweep
//  cfg     | apb psel/penable/pwrite      | radius, sweep start/end, tolerance
//
//  one beat per cycle in both directions while the output is not stalled; an
//  item passes CORDIC_STAGES + 6 registers: hub offset, prescale, the cordic
//  iteration stages (one iteration per register), gain product, rounding,
//  compares and the output register
//  each stage holds its item until the stage above frees up, so bubbles
//  collapse and the input keeps taking beats while the output is stalled
//  until every stage is full
//  rst_n is synchronous active low; it clears the valid bits, data registers
//  keep their contents
//  configuration registers reset to zero and may be rewritten only while idle
//
module arc_point_hit_test #(
  parameter int CORDIC_STAGES = 20,
  parameter int COORD_BITS    = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_probe_x,
  input  logic signed [31:0] in_probe_y,
  input  logic signed [31:0] in_hub_x,
  input  logic signed [31:0] in_hub_y,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_is_near,
  output logic               out_radial_ok,
  output logic               out_in_sweep,
  // configuration port
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [3:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);
  import aph_pkg::*;

  localparam int N     = CORDIC_STAGES;
  localparam int CW    = COORD_BITS;
  localparam int GUARD = 60 - COORD_BITS;       // fraction bits added in the cordic
  localparam int DW    = XW - GUARD;            // distance width, unsigned integer (q36.0 at the default COORD_BITS)
  localparam int EW    = ((DW > 31) ? DW : 31) + 1;  // radial error compare width
  localparam int NS    = N + 6;                 // total pipeline stages

  // stage positions
  localparam int S_DIFF = 0;
  localparam int S_PRE  = 1;
  localparam int S_MUL  = N + 2;
  localparam int S_DIST = N + 3;
  localparam int S_ERR  = N + 4;
  localparam int S_OUT  = N + 5;

  localparam logic [XW-1:0] DIST_HALF = XW'(1) << (GUARD - 1);

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [30:0]   radius_r;
  logic [AW-1:0] start_r;
  logic [AW-1:0] end_r;
  logic [30:0]   tol_r;
  reg_idx_t      cfg_idx;
  logic          cfg_wr;

  assign cfg_idx    = reg_idx_t'(cfg_paddr[3:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= '0;
      start_r  <= '0;
      end_r    <= '0;
      tol_r    <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_RADIUS: radius_r <= cfg_pwdata[30:0];
        REG_START:  start_r  <= cfg_pwdata[AW-1:0];
        REG_END:    end_r    <= cfg_pwdata[AW-1:0];
        REG_TOL:    tol_r    <= cfg_pwdata[30:0];
        default:    radius_r <= radius_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_RADIUS: cfg_prdata = {1'b0, radius_r};
      REG_START:  cfg_prdata = {16'd0, start_r};
      REG_END:    cfg_prdata = {16'd0, end_r};
      REG_TOL:    cfg_prdata = {1'b0, tol_r};
      default:    cfg_prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // pipeline flow control: a stage may load when any stage from it to the
  // output is empty or when the output beat is taken
  // --------------------------------------------------------------------------
  logic [NS-1:0] v_r;
  logic [NS-1:0] adv;

  always_comb begin
    for (int s = 0; s < NS; s++) begin
      adv[s] = out_ready || !(&(v_r | ~({NS{1'b1}} << s)));
    end
  end

  assign in_ready  = adv[S_DIFF];
  assign out_valid = v_r[S_OUT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[S_DIFF]) v_r[S_DIFF] <= in_valid;
      for (int s = 1; s < NS; s++) begin
        if (adv[s]) v_r[s] <= v_r[s-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage 0: offsets from hub to probe, one extra bit so nothing wraps
  // --------------------------------------------------------------------------
  logic signed [CW-1:0] px, py, hx, hy;
  logic signed [CW:0]   dx_r, dy_r;

  assign px = CW'($unsigned(in_probe_x));
  assign py = CW'($unsigned(in_probe_y));
  assign hx = CW'($unsigned(in_hub_x));
  assign hy = CW'($unsigned(in_hub_y));

  always_ff @(posedge clk) begin
    if (adv[S_DIFF]) begin
      dx_r <= (CW+1)'(px) - (CW+1)'(hx);
      dy_r <= (CW+1)'(py) - (CW+1)'(hy);
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: scale up, turn a left-half offset by half a turn, flag the
  // probe-at-hub case (distance 0, angle 0)
  // --------------------------------------------------------------------------
  logic signed [XW-1:0] x_r  [0:N];
  logic signed [XW-1:0] y_r  [0:N];
  logic [ZW-1:0]        z_r  [0:N];
  logic                 zf_r [0:N];
  logic signed [XW-1:0] xe, ye;

  assign xe = XW'(dx_r) <<< GUARD;
  assign ye = XW'(dy_r) <<< GUARD;

  always_ff @(posedge clk) begin
    if (adv[S_PRE]) begin
      x_r[0]  <= dx_r[CW] ? -xe : xe;
      y_r[0]  <= dx_r[CW] ? -ye : ye;
      z_r[0]  <= dx_r[CW] ? HALF_TURN : '0;
      zf_r[0] <= (dx_r == '0) && (dy_r == '0);
    end
  end

  // --------------------------------------------------------------------------
  // cordic vectoring, one micro-rotation per stage, drives y toward zero
  // --------------------------------------------------------------------------
  for (genvar i = 0; i < N; i++) begin : g_cordic
    logic signed [XW-1:0] xs, ys, xn, yn;
    logic [ZW-1:0]        zn;

    always_comb begin
      xs = x_r[i] >>> i;
      ys = y_r[i] >>> i;
      if (!y_r[i][XW-1]) begin
        xn = x_r[i] + ys;
        yn = y_r[i] - xs;
        zn = z_r[i] + ATAN_TAB[i];
      end else begin
        xn = x_r[i] - ys;
        yn = y_r[i] + xs;
        zn = z_r[i] - ATAN_TAB[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv[S_PRE+1+i]) begin
        x_r[i+1]  <= xn;
        y_r[i+1]  <= yn;
        z_r[i+1]  <= zn;
        zf_r[i+1] <= zf_r[i];
      end
    end
  end

  // --------------------------------------------------------------------------
  // gain compensation: magnitude times 1/K, split in two 32x32 products
  // --------------------------------------------------------------------------
  logic [XW-1:0] prod_hi_r, prod_lo_r;
  logic [ZW-1:0] z_mul_r;
  logic          zf_mul_r;
  logic [XW-1:0] mag;

  assign mag = $unsigned(x_r[N]);

  always_ff @(posedge clk) begin
    if (adv[S_MUL]) begin
      prod_hi_r <= XW'(mag[63:32]) * XW'(INV_GAIN);
      prod_lo_r <= XW'(mag[31:0]) * XW'(INV_GAIN);
      z_mul_r   <= z_r[N];
      zf_mul_r  <= zf_r[N];
    end
  end

  // --------------------------------------------------------------------------
  // distance rounded half up to an unsigned integer (q36.0 by default), angle rounded half up to 16 bits
  // --------------------------------------------------------------------------
  logic [XW-1:0] scaled;
  logic [ZW-1:0] z_rnd;
  logic [DW-1:0] dist_r;
  logic [AW-1:0] ang_r;

  assign scaled = prod_hi_r + {32'd0, prod_lo_r[63:32]} + DIST_HALF;
  assign z_rnd  = z_mul_r + ANG_ROUND;

  always_ff @(posedge clk) begin
    if (adv[S_DIST]) begin
      dist_r <= scaled[XW-1:GUARD];
      ang_r  <= zf_mul_r ? '0 : z_rnd[ZW-1:ZW-AW];
    end
  end

  // --------------------------------------------------------------------------
  // radial error magnitude and sweep compares
  // --------------------------------------------------------------------------
  logic [EW-1:0] dist_e, rad_e;
  logic [EW-1:0] err_r;
  logic          ge_start_r, le_end_r, wrap_r;

  assign dist_e = EW'(dist_r);
  assign rad_e  = EW'(radius_r);

  always_ff @(posedge clk) begin
    if (adv[S_ERR]) begin
      err_r      <= (dist_e >= rad_e) ? (dist_e - rad_e) : (rad_e - dist_e);
      ge_start_r <= ang_r >= start_r;
      le_end_r   <= ang_r <= end_r;
      wrap_r     <= end_r < start_r;
    end
  end

  // --------------------------------------------------------------------------
  // output register
  // --------------------------------------------------------------------------
  logic radial_ok, sweep_ok;

  assign radial_ok = err_r <= EW'(tol_r);
  // a sweep with end below start runs through zero
  assign sweep_ok  = wrap_r ? (ge_start_r || le_end_r) : (ge_start_r && le_end_r);

  logic near_r, radial_r, sweep_r;

  always_ff @(posedge clk) begin
    if (adv[S_OUT]) begin
      near_r   <= radial_ok && sweep_ok;
      radial_r <= radial_ok;
      sweep_r  <= sweep_ok;
    end
  end

  assign out_is_near   = near_r;
  assign out_radial_ok = radial_r;
  assign out_in_sweep  = sweep_r;

endmodule

>>> design/aph_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aph_checker
// port-level checks for the arc point hit test, bound to the top level
// ----------------------------------------------------------------------------
module aph_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_is_near,
  input logic out_radial_ok,
  input logic out_in_sweep,
  input logic cfg_pready
);

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // near is exactly radial and sweep together
  a_near_and: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_near == (out_radial_ok && out_in_sweep)))
    else $error("is_near disagrees with radial_ok and in_sweep");

  // a taken output beat always frees room for an input beat
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while output drains");

  // a stalled result beat stays
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // a stalled result beat keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      $stable(out_is_near) && $stable(out_radial_ok) && $stable(out_in_sweep))
    else $error("result payload changed while stalled");

endmodule

bind arc_point_hit_test aph_checker u_aph_checker (.*);
